@@ rtl/ceid_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ceid_pkg
// Shared types and constants for the compacted extent index decoder.
// ----------------------------------------------------------------------------
package ceid_pkg;

  localparam int BLOCK_SHIFT     = 12;        // 4096-byte blocks
  localparam int MAX_EXTENTS_DEF = 131072;
  localparam int NUM_LANES       = 16;
  localparam int ENT_W           = 14;

  // configuration register indexes
  localparam logic [1:0] CFG_CLUSTER_SHIFT = 2'd0;
  localparam logic [1:0] CFG_TOTAL_BYTES   = 2'd1;
  localparam logic [1:0] CFG_EXTENT_COUNT  = 2'd2;

  // input op codes
  localparam logic [1:0] OP_PAIR   = 2'd0;
  localparam logic [1:0] OP_SINGLE = 2'd1;
  localparam logic [1:0] OP_GROUP  = 2'd2;

  // entry types
  localparam logic [1:0] TYPE_PLAIN   = 2'd0;
  localparam logic [1:0] TYPE_FIRST   = 2'd1;
  localparam logic [1:0] TYPE_NONHEAD = 2'd2;

  // result kinds
  localparam logic [1:0] KIND_PLAIN  = 2'd0;
  localparam logic [1:0] KIND_FIRST  = 2'd1;
  localparam logic [1:0] KIND_SECOND = 2'd2;

  // error codes
  localparam logic [1:0] ERR_NONE    = 2'd0;
  localparam logic [1:0] ERR_OFFSET  = 2'd1;
  localparam logic [1:0] ERR_TOOMANY = 2'd2;
  localparam logic [1:0] ERR_CLUSTER = 2'd3;

  typedef struct packed {
    logic        head;
    logic [1:0]  kind;
    logic        gt;     // offset beyond total size
    logic        eq;     // offset equals total size
    logic [29:0] off;
  } lane_t;

  typedef struct packed {
    logic [16:0] idx;
    logic [29:0] off;
    logic [29:0] len;
    logic [43:0] addr;
    logic [1:0]  kind;
    logic        done;
    logic [1:0]  err;
  } res_t;

  typedef struct packed {
    logic        go;     // decode n entries from the lanes
    logic        err3;   // group word with wrong cluster size
    logic [4:0]  n;
    logic [31:0] base;
  } cmd_t;

  typedef struct packed {
    logic        idle;
    logic        err;
    logic [17:0] cc;
  } stat_t;

endpackage

@@ rtl/ceid_in_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ceid_in_if
// Index word channel: op code and eight index bytes.
// ----------------------------------------------------------------------------
interface ceid_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  op;
  logic [63:0] word;

  modport source (output valid, op, word, input ready);
  modport sink   (input valid, op, word, output ready);
endinterface

@@ rtl/ceid_out_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ceid_out_if
// Extent result channel.
// ----------------------------------------------------------------------------
interface ceid_out_if;
  logic        valid;
  logic        ready;
  logic [16:0] extent_index;
  logic [29:0] uncompressed_offset;
  logic [29:0] uncompressed_length;
  logic [43:0] compressed_byte_addr;
  logic [1:0]  compression_kind;
  logic        map_complete;
  logic [1:0]  error_code;
  logic        last;

  modport source (output valid, extent_index, uncompressed_offset, uncompressed_length,
                  compressed_byte_addr, compression_kind, map_complete, error_code, last,
                  input ready);
  modport sink   (input valid, extent_index, uncompressed_offset, uncompressed_length,
                  compressed_byte_addr, compression_kind, map_complete, error_code, last,
                  output ready);
endinterface

@@ rtl/ceid_lane.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ceid_lane
// One entry decoder: type, cluster offset and size compare, registered.
// ----------------------------------------------------------------------------
module ceid_lane #(
  parameter int LANE = 0
) (
  input  logic               clk,
  input  logic               load,
  input  logic [15:0]        ent,
  input  logic [17:0]        cc,
  input  logic [2:0]         shift,
  input  logic [29:0]        total,
  output ceid_pkg::lane_t    lane_r
);
  import ceid_pkg::*;

  logic [18:0] pos;
  logic [4:0]  sh;
  logic [19:0] mask;
  logic [37:0] off;
  logic [1:0]  typ;
  lane_t       lane_nxt;

  always_comb begin
    pos  = 19'(cc) + 19'(LANE);
    sh   = 5'(BLOCK_SHIFT) + 5'(shift);
    mask = (20'd1 << sh) - 20'd1;
    off  = (38'(pos) << sh) | 38'(ent & mask[15:0]);
    typ  = ent[13:12];
    lane_nxt.head = (typ != TYPE_NONHEAD);
    case (typ)
      TYPE_PLAIN: lane_nxt.kind = KIND_PLAIN;
      TYPE_FIRST: lane_nxt.kind = KIND_FIRST;
      default:    lane_nxt.kind = KIND_SECOND;
    endcase
    lane_nxt.gt  = off > 38'(total);
    lane_nxt.eq  = off == 38'(total);
    lane_nxt.off = off[29:0];
  end

  always_ff @(posedge clk) begin
    if (load) begin
      lane_r <= lane_nxt;
    end
  end

endmodule

@@ rtl/ceid_merge.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ceid_merge
// Walks the lane results in order, tracks the pending extent and emits words.
// ----------------------------------------------------------------------------
module ceid_merge #(
  parameter int MAX_EXTENTS = ceid_pkg::MAX_EXTENTS_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  ceid_pkg::cmd_t       cmd,
  input  ceid_pkg::lane_t      lanes [ceid_pkg::NUM_LANES],
  input  logic [29:0]          total,
  input  logic [17:0]          count,
  output ceid_pkg::stat_t      stat,
  output logic                 load,
  output logic                 out_valid,
  input  logic                 out_ready,
  output ceid_pkg::res_t       out_res,
  output logic                 out_last
);
  import ceid_pkg::*;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_LOAD  = 3'd1;
  localparam logic [2:0] S_RUN   = 3'd2;
  localparam logic [2:0] S_FLUSH = 3'd3;

  logic [2:0]  state_r, state_nxt;
  logic [4:0]  i_r, i_nxt;
  logic [4:0]  n_r, n_nxt;
  logic        sub_r, sub_nxt;
  logic [31:0] blk_r, blk_nxt;
  logic [17:0] cc_r, cc_nxt;
  logic [17:0] nei_r, nei_nxt;
  logic        err_r, err_nxt;
  logic        pv_r, pv_nxt;
  logic [29:0] poff_r, poff_nxt;
  logic [31:0] pblk_r, pblk_nxt;
  logic [1:0]  pkind_r, pkind_nxt;
  logic        hold_v_r, hold_v_nxt;
  res_t        hold_r, hold_nxt;
  logic        out_v_r, out_v_nxt;
  res_t        out_r, out_nxt;
  logic        last_r, last_nxt;

  logic [17:0] ec;
  logic        out_free, can_emit, emit;
  res_t        nres;
  lane_t       cur;

  assign ec = (32'(count) > 32'(MAX_EXTENTS)) ? 18'(MAX_EXTENTS) : count;
  assign out_free = !out_v_r || out_ready;
  assign can_emit = !hold_v_r || out_free;
  assign cur      = lanes[i_r[3:0]];

  always_comb begin
    state_nxt  = state_r;
    i_nxt      = i_r;
    n_nxt      = n_r;
    sub_nxt    = sub_r;
    blk_nxt    = blk_r;
    cc_nxt     = cc_r;
    nei_nxt    = nei_r;
    err_nxt    = err_r;
    pv_nxt     = pv_r;
    poff_nxt   = poff_r;
    pblk_nxt   = pblk_r;
    pkind_nxt  = pkind_r;
    hold_v_nxt = hold_v_r;
    hold_nxt   = hold_r;
    out_v_nxt  = out_v_r && !out_ready;
    out_nxt    = out_r;
    last_nxt   = last_r;
    emit       = 1'b0;
    nres       = '0;

    case (state_r)
      S_IDLE: begin
        if (cmd.err3) begin
          nres.err  = ERR_CLUSTER;
          emit      = 1'b1;
          err_nxt   = 1'b1;
          state_nxt = S_FLUSH;
        end else if (cmd.go) begin
          n_nxt     = cmd.n;
          i_nxt     = '0;
          sub_nxt   = 1'b0;
          blk_nxt   = cmd.base + 32'd1;
          state_nxt = S_LOAD;
        end
      end
      S_LOAD: state_nxt = S_RUN;
      S_RUN: begin
        if (i_r == n_r) begin
          cc_nxt    = cc_r + 18'(n_r);
          state_nxt = S_FLUSH;
        end else if (!cur.head) begin
          i_nxt = i_r + 5'd1;
        end else if (cur.gt || (!cur.eq && nei_r >= ec)) begin
          if (can_emit) begin
            nres.err  = cur.gt ? ERR_OFFSET : ERR_TOOMANY;
            emit      = 1'b1;
            err_nxt   = 1'b1;
            state_nxt = S_FLUSH;
          end
        end else if (cur.eq) begin
          // head at end of file: ignored but uses its block
          blk_nxt = blk_r + 32'd1;
          i_nxt   = i_r + 5'd1;
        end else if (pv_r && !sub_r) begin
          if (can_emit) begin
            nres.idx  = 17'(nei_r - 18'd1);
            nres.off  = poff_r;
            nres.len  = cur.off - poff_r;
            nres.addr = {pblk_r, 12'd0};
            nres.kind = pkind_r;
            emit      = 1'b1;
            sub_nxt   = 1'b1;
          end
        end else if ({1'b0, nei_r} == 19'(ec) - 19'd1) begin
          if (can_emit) begin
            nres.idx  = 17'(nei_r);
            nres.off  = cur.off;
            nres.len  = total - cur.off;
            nres.addr = {blk_r, 12'd0};
            nres.kind = cur.kind;
            nres.done = 1'b1;
            emit      = 1'b1;
            pv_nxt    = 1'b0;
            nei_nxt   = nei_r + 18'd1;
            blk_nxt   = blk_r + 32'd1;
            i_nxt     = i_r + 5'd1;
            sub_nxt   = 1'b0;
          end
        end else begin
          pv_nxt    = 1'b1;
          poff_nxt  = cur.off;
          pblk_nxt  = blk_r;
          pkind_nxt = cur.kind;
          nei_nxt   = nei_r + 18'd1;
          blk_nxt   = blk_r + 32'd1;
          i_nxt     = i_r + 5'd1;
          sub_nxt   = 1'b0;
        end
      end
      S_FLUSH: begin
        if (!hold_v_r) begin
          state_nxt = S_IDLE;
        end else if (out_free) begin
          out_v_nxt  = 1'b1;
          out_nxt    = hold_r;
          last_nxt   = 1'b1;
          hold_v_nxt = 1'b0;
          state_nxt  = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase

    // a new word pushes the held one out; last is only known at flush
    if (emit) begin
      if (hold_v_r) begin
        out_v_nxt = 1'b1;
        out_nxt   = hold_r;
        last_nxt  = 1'b0;
      end
      hold_v_nxt = 1'b1;
      hold_nxt   = nres;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      cc_r     <= '0;
      nei_r    <= '0;
      err_r    <= 1'b0;
      pv_r     <= 1'b0;
      poff_r   <= '0;
      pblk_r   <= '0;
      pkind_r  <= '0;
      hold_v_r <= 1'b0;
      out_v_r  <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      cc_r     <= cc_nxt;
      nei_r    <= nei_nxt;
      err_r    <= err_nxt;
      pv_r     <= pv_nxt;
      poff_r   <= poff_nxt;
      pblk_r   <= pblk_nxt;
      pkind_r  <= pkind_nxt;
      hold_v_r <= hold_v_nxt;
      out_v_r  <= out_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    i_r    <= i_nxt;
    n_r    <= n_nxt;
    sub_r  <= sub_nxt;
    blk_r  <= blk_nxt;
    hold_r <= hold_nxt;
    out_r  <= out_nxt;
    last_r <= last_nxt;
  end

  assign load      = (state_r == S_LOAD);
  assign stat.idle = (state_r == S_IDLE);
  assign stat.err  = err_r;
  assign stat.cc   = cc_r;
  assign out_valid = out_v_r;
  assign out_res   = out_r;
  assign out_last  = last_r;

endmodule

@@ rtl/compacted_extent_index_decoder.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// compacted_extent_index_decoder
// Decodes a compacted cluster index stream into an extent map.
// ----------------------------------------------------------------------------
// One index word is taken at a time, when the decoder is idle. Group quarters
// one to three are only stored. A record or the fourth group quarter passes a
// load state, a run state walking each entry (2, 1 or 16) with an extra step
// per head that closes a pending extent, and a flush state marking the last
// word; output stalls hold the walk. Sixteen lanes decode all entries of a
// word at once; the serial walk of the merge stage, emitting at most one result
// word per cycle when the output is not stalled, sets the rate. Errors are sticky until reset.
module compacted_extent_index_decoder #(
  parameter int MAX_EXTENTS = ceid_pkg::MAX_EXTENTS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  ceid_in_if.sink     in_ch,
  ceid_out_if.source  out_ch,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_addr,
  input  logic [29:0] cfg_wdata
);
  import ceid_pkg::*;

  logic [2:0]   shift_r;
  logic [29:0]  total_r;
  logic [17:0]  count_r;
  logic [63:0]  gbuf_r [3];
  logic [1:0]   gwc_r;
  logic [255:0] work_r;
  logic         grp_r;
  logic         acc;
  cmd_t         cmd;
  stat_t        stat;
  logic         load;
  lane_t        lanes [NUM_LANES];
  res_t         res;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      shift_r <= '0;
      total_r <= '0;
      count_r <= 18'd1;
    end else if (cfg_we) begin
      case (cfg_addr)
        CFG_CLUSTER_SHIFT: shift_r <= cfg_wdata[2:0];
        CFG_TOTAL_BYTES:   total_r <= cfg_wdata;
        CFG_EXTENT_COUNT:  count_r <= cfg_wdata[17:0];
        default: ;
      endcase
    end
  end

  assign in_ch.ready = stat.idle;
  assign acc = in_ch.valid && stat.idle && !stat.err;

  always_comb begin
    cmd      = '0;
    cmd.base = in_ch.word[63:32];
    if (acc) begin
      case (in_ch.op)
        OP_PAIR: begin
          cmd.go = 1'b1;
          cmd.n  = 5'd2;
        end
        OP_SINGLE: begin
          cmd.go = 1'b1;
          cmd.n  = 5'd1;
        end
        OP_GROUP: begin
          if (shift_r != 3'd0) begin
            cmd.err3 = 1'b1;
          end else if (gwc_r == 2'd3) begin
            cmd.go = 1'b1;
            cmd.n  = 5'(NUM_LANES);
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gwc_r <= '0;
    end else if (acc) begin
      if (in_ch.op == OP_PAIR || in_ch.op == OP_SINGLE) begin
        gwc_r <= '0;
      end else if (in_ch.op == OP_GROUP && shift_r == 3'd0) begin
        gwc_r <= gwc_r + 2'd1;
      end
    end
  end

  // records sit in the low word; a full group spans all four
  always_ff @(posedge clk) begin
    if (acc && in_ch.op == OP_GROUP && gwc_r != 2'd3) begin
      gbuf_r[gwc_r] <= in_ch.word;
    end
    if (cmd.go) begin
      grp_r <= (in_ch.op == OP_GROUP);
      if (in_ch.op == OP_GROUP) begin
        work_r <= {in_ch.word, gbuf_r[2], gbuf_r[1], gbuf_r[0]};
      end else begin
        work_r <= {192'd0, in_ch.word};
      end
    end
  end

  for (genvar g = 0; g < NUM_LANES; g++) begin : g_lane
    logic [15:0] ent;
    if (g < 2) begin : g_rec
      assign ent = grp_r ? 16'(work_r[g*ENT_W +: ENT_W]) : work_r[g*16 +: 16];
    end else begin : g_grp
      assign ent = 16'(work_r[g*ENT_W +: ENT_W]);
    end
    ceid_lane #(.LANE(g)) u_lane (
      .clk    (clk),
      .load   (load),
      .ent    (ent),
      .cc     (stat.cc),
      .shift  (shift_r),
      .total  (total_r),
      .lane_r (lanes[g])
    );
  end

  ceid_merge #(.MAX_EXTENTS(MAX_EXTENTS)) u_merge (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .lanes     (lanes),
    .total     (total_r),
    .count     (count_r),
    .stat      (stat),
    .load      (load),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .out_res   (res),
    .out_last  (out_ch.last)
  );

  assign out_ch.extent_index         = res.idx;
  assign out_ch.uncompressed_offset  = res.off;
  assign out_ch.uncompressed_length  = res.len;
  assign out_ch.compressed_byte_addr = res.addr;
  assign out_ch.compression_kind     = res.kind;
  assign out_ch.map_complete         = res.done;
  assign out_ch.error_code           = res.err;

endmodule

@@ rtl/ceid_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ceid_checker
// Port-level checks on the result channel, bound to the top level.
// ----------------------------------------------------------------------------
module ceid_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_ready,
  input logic [16:0] extent_index,
  input logic [29:0] uncompressed_length,
  input logic        map_complete,
  input logic [1:0]  error_code,
  input logic        last
);

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result word dropped while stalled");

  a_err_word: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && error_code != 2'd0 |->
      last && !map_complete && extent_index == 17'd0 && uncompressed_length == 30'd0)
    else $error("error word carries extent data");

  a_err_final: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && error_code != 2'd0 |=> !out_valid)
    else $error("word after error");

endmodule

bind compacted_extent_index_decoder ceid_checker u_ceid_checker (
  .clk                 (clk),
  .rst_n               (rst_n),
  .out_valid           (out_ch.valid),
  .out_ready           (out_ch.ready),
  .extent_index        (out_ch.extent_index),
  .uncompressed_length (out_ch.uncompressed_length),
  .map_complete        (out_ch.map_complete),
  .error_code          (out_ch.error_code),
  .last                (out_ch.last)
);

@@ dv/compacted_extent_index_decoder_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// compacted_extent_index_decoder_tb
// Self-checking bench for the compacted cluster index decoder: drives pair
// records, single records and group words, predicts the extent map in
// parallel and checks every result word in order, under varying backpressure.
// ----------------------------------------------------------------------------
module compacted_extent_index_decoder_tb;
  import ceid_pkg::*;

  localparam int WD_LIMIT = 5000;
  localparam int SETTLE   = 50;
  localparam logic [63:0] EXT_LIMIT = 64'd131072;

  typedef struct packed {
    res_t r;
    logic last;
  } extent_t;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [1:0] cfg_addr;
  logic [29:0] cfg_wdata;

  ceid_in_if in_ch ();
  ceid_out_if out_ch ();

  compacted_extent_index_decoder dut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch.sink), .out_ch(out_ch.source),
    .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata)
  );

  // decoder shadow state
  logic [2:0] shift_q;
  logic [29:0] total_q;
  logic [17:0] ecount_q;
  logic [17:0] cluster_q;
  logic [63:0] grp_buf [3];
  logic [1:0] grp_cnt;
  logic [17:0] ext_idx;
  logic pend_v;
  logic [29:0] pend_off;
  logic [44:0] pend_addr;
  logic [1:0] pend_kind;
  logic sticky_err;

  extent_t word_res[$];
  extent_t extent_q[$];
  int errors = 0;
  int src_idle = 0;
  int snk_idle = 0;
  int quiet_cycles = 0;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  task automatic report(string what, logic [63:0] got, logic [63:0] want);
    $display("mismatch %s: got %0h want %0h", what, got, want);
    errors++;
  endtask

  function automatic void push_res(logic [17:0] idx, logic [63:0] off, logic [63:0] len,
                                   logic [44:0] addr, logic [1:0] kind, logic done,
                                   logic [1:0] err);
    extent_t e;
    e.r.idx = idx[16:0];
    e.r.off = off[29:0];
    e.r.len = len[29:0];
    e.r.addr = addr[43:0];
    e.r.kind = kind;
    e.r.done = done;
    e.r.err = err;
    e.last = 1'b0;
    word_res.push_back(e);
  endfunction

  function automatic logic [1:0] open_extent(logic [1:0] typ, logic [63:0] off,
                                             logic [63:0] blk);
    logic [63:0] lim;
    logic [17:0] idx;
    logic [1:0] kind;
    logic [44:0] baddr;
    lim = (ecount_q > EXT_LIMIT) ? EXT_LIMIT : 64'(ecount_q);
    if (off > total_q) return ERR_OFFSET;
    if (off == total_q) return ERR_NONE;
    if (ext_idx >= lim) return ERR_TOOMANY;
    if (pend_v) push_res(ext_idx - 18'd1, pend_off, off - pend_off, pend_addr, pend_kind,
                         1'b0, ERR_NONE);
    idx = ext_idx;
    ext_idx = ext_idx + 18'd1;
    kind = (typ == TYPE_PLAIN) ? KIND_PLAIN : (typ == TYPE_FIRST) ? KIND_FIRST : KIND_SECOND;
    baddr = 45'(blk << BLOCK_SHIFT);
    if (64'(idx) == lim - 64'd1) begin
      push_res(idx, off, 64'(total_q) - off, baddr, kind, 1'b1, ERR_NONE);
      pend_v = 1'b0;
    end else begin
      pend_v = 1'b1;
      pend_off = off[29:0];
      pend_addr = baddr;
      pend_kind = kind;
    end
    return ERR_NONE;
  endfunction

  function automatic void decode_word(logic [1:0] op, logic [63:0] w);
    logic [255:0] all;
    logic [15:0] ent [16];
    logic [63:0] blk, csize, off;
    logic [1:0] typ, err;
    int n;
    if (sticky_err || op == 2'd3) return;
    if (op == OP_GROUP) begin
      if (shift_q != 3'd0) begin
        sticky_err = 1'b1;
        push_res('0, '0, '0, '0, '0, 1'b0, ERR_CLUSTER);
        return;
      end
      if (grp_cnt < 2'd3) begin
        grp_buf[grp_cnt] = w;
        grp_cnt++;
        return;
      end
      grp_cnt = 2'd0;
      all = {w, grp_buf[2], grp_buf[1], grp_buf[0]};
      for (int i = 0; i < 16; i++) ent[i] = {2'b00, all[i*ENT_W +: ENT_W]};
      n = 16;
      csize = 64'd1 << BLOCK_SHIFT;
    end else begin
      grp_cnt = 2'd0;
      ent[0] = w[15:0];
      ent[1] = w[31:16];
      n = (op == OP_PAIR) ? 2 : 1;
      csize = 64'd1 << (BLOCK_SHIFT + shift_q);
    end
    blk = 64'(w[63:32]) + 64'd1;
    for (int i = 0; i < n; i++) begin
      typ = ent[i][13:12];
      if (typ != TYPE_NONHEAD) begin
        off = ((64'(cluster_q) + i) * csize) | (64'(ent[i]) & (csize - 64'd1));
        err = open_extent(typ, off, blk);
        if (err != ERR_NONE) begin
          sticky_err = 1'b1;
          push_res('0, '0, '0, '0, '0, 1'b0, err);
          return;
        end
        blk++;
      end
    end
    cluster_q = cluster_q + 18'(n);
  endfunction

  task automatic predict_word(logic [1:0] op, logic [63:0] w);
    word_res.delete();
    decode_word(op, w);
    if (word_res.size() > 0) word_res[word_res.size()-1].last = 1'b1;
    foreach (word_res[i]) extent_q.push_back(word_res[i]);
  endtask

  task automatic send_word(logic [1:0] op, logic [63:0] w);
    while ($urandom_range(99) < src_idle) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.op <= op;
    in_ch.word <= w;
    do @(posedge clk); while (!in_ch.ready);
    predict_word(op, w);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [29:0] val);
    cfg_we <= 1'b1;
    cfg_addr <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CFG_CLUSTER_SHIFT: shift_q = val[2:0];
      CFG_TOTAL_BYTES:   total_q = val;
      CFG_EXTENT_COUNT:  ecount_q = val[17:0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  // lets results drain and the decoder go idle before a register write
  task automatic drain();
    in_ch.valid <= 1'b0;
    while (extent_q.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  function automatic logic [63:0] rnd64();
    return {$urandom, $urandom};
  endfunction

  task automatic test_directed();
    write_reg(CFG_CLUSTER_SHIFT, 30'd0);
    write_reg(CFG_TOTAL_BYTES, 30'd536870912);
    write_reg(CFG_EXTENT_COUNT, 30'd1);
    // single extent map closes on its first head
    send_word(OP_SINGLE, 64'h0);
    drain();
    write_reg(CFG_EXTENT_COUNT, 30'd262143);
    send_word(OP_PAIR, {32'hffff_ffff, 16'h3abc, 16'h1fff});
    send_word(OP_PAIR, {32'h0000_1234, 16'h2000, 16'h2fff});
    send_word(2'd3, '1);
    repeat (4) send_word(OP_GROUP, '1);
    repeat (4) send_word(OP_GROUP, '0);
    // record cuts a partial group short
    send_word(OP_GROUP, rnd64());
    send_word(OP_GROUP, rnd64());
    send_word(OP_SINGLE, {32'h8000_0000, 16'h0, 16'h1abc});
    send_word(OP_PAIR, {32'h0, 16'hffff, 16'hcfff});
    drain();
    // head landing exactly on the file size is dropped
    write_reg(CFG_TOTAL_BYTES, 30'(64'(cluster_q) << BLOCK_SHIFT));
    send_word(OP_SINGLE, {32'h55, 16'h0, 16'h1000});
    drain();
    write_reg(CFG_TOTAL_BYTES, 30'd536870912);
    send_word(OP_SINGLE, {32'h77, 16'h0, 16'h0123});
  endtask

  task automatic test_random(int items, logic groups);
    int sent, r, k;
    sent = 0;
    while (sent < items) begin
      r = $urandom_range(99);
      if (groups && r < 55) begin
        repeat (4) send_word(OP_GROUP, rnd64());
        sent += 4;
      end else if (groups && r < 65) begin
        k = $urandom_range(1, 3);
        repeat (k) send_word(OP_GROUP, rnd64());
        sent += k;
      end else if (r < 95) begin
        send_word($urandom_range(1) ? OP_PAIR : OP_SINGLE, rnd64());
        sent++;
      end else begin
        send_word(2'd3, rnd64());
      end
    end
  endtask

  task automatic test_map_end();
    drain();
    write_reg(CFG_EXTENT_COUNT, 30'(ext_idx) + 30'd1);
    send_word(OP_SINGLE, {$urandom, 16'h0, 16'h1042});
    drain();
    case ($urandom_range(2))
      0: begin
        write_reg(CFG_TOTAL_BYTES, 30'd0);
        send_word(OP_SINGLE, {$urandom, 16'h0, 16'h0001});
      end
      1: send_word(OP_SINGLE, {$urandom, 16'h0, 16'h0001});
      default: begin
        write_reg(CFG_CLUSTER_SHIFT, 30'd7);
        send_word(OP_GROUP, rnd64());
      end
    endcase
    // everything after an error is ignored
    repeat (3) send_word(OP_PAIR, rnd64());
    send_word(OP_GROUP, rnd64());
  endtask

  always @(posedge clk) begin
    if (!rst_n) out_ch.ready <= 1'b0;
    else out_ch.ready <= ($urandom_range(99) >= snk_idle);
  end

  always @(posedge clk) begin
    extent_t got, want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got.r.idx = out_ch.extent_index;
      got.r.off = out_ch.uncompressed_offset;
      got.r.len = out_ch.uncompressed_length;
      got.r.addr = out_ch.compressed_byte_addr;
      got.r.kind = out_ch.compression_kind;
      got.r.done = out_ch.map_complete;
      got.r.err = out_ch.error_code;
      got.last = out_ch.last;
      if (extent_q.size() == 0) begin
        report("unexpected word", 64'(got), '0);
      end else begin
        want = extent_q.pop_front();
        if (got.r.idx !== want.r.idx) report("extent_index", 64'(got.r.idx), 64'(want.r.idx));
        if (got.r.off !== want.r.off) report("offset", 64'(got.r.off), 64'(want.r.off));
        if (got.r.len !== want.r.len) report("length", 64'(got.r.len), 64'(want.r.len));
        if (got.r.addr !== want.r.addr) report("addr", 64'(got.r.addr), 64'(want.r.addr));
        if (got.r.kind !== want.r.kind) report("kind", 64'(got.r.kind), 64'(want.r.kind));
        if (got.r.done !== want.r.done) report("complete", 64'(got.r.done), 64'(want.r.done));
        if (got.r.err !== want.r.err) report("error", 64'(got.r.err), 64'(want.r.err));
        if (got.last !== want.last) report("last", 64'(got.last), 64'(want.last));
      end
    end
  end

  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WD_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_addr = '0;
    cfg_wdata = '0;
    in_ch.valid = 1'b0;
    in_ch.op = '0;
    in_ch.word = '0;
    out_ch.ready = 1'b0;
    shift_q = '0;
    total_q = '0;
    ecount_q = 18'd1;
    cluster_q = '0;
    grp_cnt = '0;
    ext_idx = '0;
    pend_v = 1'b0;
    pend_off = '0;
    pend_addr = '0;
    pend_kind = '0;
    sticky_err = 1'b0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed();
    drain();
    src_idle = 17;
    snk_idle = 53;
    write_reg(CFG_CLUSTER_SHIFT, 30'd7);
    test_random(30, 1'b0);
    drain();
    src_idle = 53;
    snk_idle = 17;
    write_reg(CFG_CLUSTER_SHIFT, 30'd3);
    test_random(25, 1'b0);
    drain();
    src_idle = 0;
    snk_idle = 0;
    write_reg(CFG_CLUSTER_SHIFT, 30'd0);
    write_reg(CFG_EXTENT_COUNT, 30'd131072);
    test_random(70, 1'b1);
    test_map_end();
    drain();

    if (errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
